// ===== rtl/cavl_pkg.sv =====
// ----------------------------------------------------------------------------
// cavl_pkg
// Shared widths, register indexes, engine states and structs for the
// cascaded angle and velocity loop core.
// ----------------------------------------------------------------------------
package cavl_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 31;
    localparam int VLIM_W     = 15;
    localparam int DRIVE_W    = 16;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = DIFF_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int ISUM_W     = DATA_W + 2;
    localparam int DSHIFT_W   = ACC_W - FRAC_BITS - GAIN_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [GAIN_W-1:0]  ANGLE_KP_RESET       = 20'd20480;
    localparam logic [GAIN_W-1:0]  ANGLE_KD_RESET       = 20'd768;
    localparam logic [GAIN_W-1:0]  VELOCITY_KP_RESET    = 20'd153600;
    localparam logic [GAIN_W-1:0]  VELOCITY_KI_RESET    = 20'd25600;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET    = 31'd1966080;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 31'd5242880;
    localparam logic [VLIM_W-1:0]  VOLTAGE_LIMIT_RESET  = 15'd26000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_KP       = 3'd0,
        CFG_ANGLE_KD       = 3'd1,
        CFG_VELOCITY_KP    = 3'd2,
        CFG_VELOCITY_KI    = 3'd3,
        CFG_SPEED_LIMIT    = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_VOLTAGE_LIMIT  = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_FETCH,
        ENG_PD_A,
        ENG_PD_SUM,
        ENG_VERR,
        ENG_INTEG,
        ENG_PI_B,
        ENG_PI_SUM,
        ENG_DRIVE
    } eng_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  angle_kp;
        logic [GAIN_W-1:0]  angle_kd;
        logic [GAIN_W-1:0]  velocity_kp;
        logic [GAIN_W-1:0]  velocity_ki;
        logic [LIMIT_W-1:0] speed_limit;
        logic [LIMIT_W-1:0] integral_limit;
        logic [VLIM_W-1:0]  voltage_limit;
    } cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic [CH_W-1:0]   rd_addr;
        logic              wr_en;
        logic [CH_W-1:0]   wr_addr;
        logic [DATA_W-1:0] wr_error;
        logic [DATA_W-1:0] wr_integral;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] error;
        logic [DATA_W-1:0] integral;
    } mem_rd_t;

endpackage

// ===== rtl/cavl_in_if.sv =====
// ----------------------------------------------------------------------------
// cavl_in_if
// Valid/ready channel that carries one sample word: channel, angle error and
// measured velocity.
// ----------------------------------------------------------------------------
interface cavl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [cavl_pkg::CH_W-1:0]             channel;
    logic signed [cavl_pkg::DATA_W-1:0]    angle_error;
    logic signed [cavl_pkg::DATA_W-1:0]    measured_velocity;

    modport source (output valid, output channel, output angle_error,
                    output measured_velocity, input ready);
    modport sink (input valid, input channel, input angle_error,
                  input measured_velocity, output ready);
endinterface

// ===== rtl/cavl_out_if.sv =====
// ----------------------------------------------------------------------------
// cavl_out_if
// Valid/ready channel that carries one drive word.
// ----------------------------------------------------------------------------
interface cavl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cavl_pkg::DRIVE_W-1:0]   drive_voltage;

    modport source (output valid, output drive_voltage, input ready);
    modport sink (input valid, input drive_voltage, output ready);
endinterface

// ===== rtl/cavl_state_mem.sv =====
// ----------------------------------------------------------------------------
// cavl_state_mem
// Per-channel state memory holding the previous angle error and the velocity
// integral, with registered read data and per-entry valid bits.
// ----------------------------------------------------------------------------
module cavl_state_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  cavl_pkg::mem_req_t req,
    output cavl_pkg::mem_rd_t  rd
);

    cavl_pkg::mem_rd_t                 mem [cavl_pkg::CHANNELS];
    logic [cavl_pkg::CHANNELS-1:0]     valid_reg;
    logic                              rd_valid_reg;
    cavl_pkg::mem_rd_t                 rd_data_reg;

    // Entries never written read as zero, which matches the cleared state.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= '{error: req.wr_error, integral: req.wr_integral};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/cavl_engine.sv =====
// ----------------------------------------------------------------------------
// cavl_engine
// Sequencer and datapath of the cascaded loop: one shared multiplier and one
// accumulator step through the PD and PI terms of a sample.
// ----------------------------------------------------------------------------
module cavl_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    cavl_in_if.sink                             sample,
    input  cavl_pkg::cfg_t                      cfg,
    output cavl_pkg::mem_req_t                  mem_req,
    input  cavl_pkg::mem_rd_t                   mem_rd,
    output logic                                res_valid,
    output logic signed [cavl_pkg::DRIVE_W-1:0] res_drive,
    input  logic                                res_ready
);

    localparam int DW = cavl_pkg::DATA_W;
    localparam int GF = cavl_pkg::GAIN_FRAC;
    localparam int TS = cavl_pkg::FRAC_BITS + cavl_pkg::GAIN_FRAC;
    localparam int AW = cavl_pkg::ACC_W;

    cavl_pkg::eng_state_t state_reg, state_next;

    logic [cavl_pkg::CH_W-1:0]                  ch_reg;
    logic signed [DW-1:0]                       err_reg;
    logic signed [DW-1:0]                       vel_reg;
    logic signed [cavl_pkg::DIFF_W-1:0]         derr_reg, derr_next;
    logic signed [DW-1:0]                       iold_reg;
    logic signed [cavl_pkg::DIFF_W-1:0]         verr_reg, verr_next;
    logic signed [DW-1:0]                       integ_reg, integ_next;
    logic signed [cavl_pkg::PROD_W-1:0]         prod_reg, mul_p;
    logic signed [AW-1:0]                       acc_reg, acc_next;
    logic signed [cavl_pkg::DIFF_W-1:0]         mul_a;
    logic signed [cavl_pkg::MUL_B_W-1:0]        mul_b;

    logic signed [AW-1:0]                       sum;
    logic signed [AW-1:0]                       spd_lim;
    logic signed [AW-1:0]                       t_shift;
    logic signed [cavl_pkg::DIFF_W-1:0]         target;
    logic signed [cavl_pkg::ISUM_W-1:0]         isum, ilim, ilim_neg;
    logic signed [AW-1:0]                       d_shift;
    logic signed [cavl_pkg::DSHIFT_W-1:0]       d_trunc, vlim, vlim_neg;
    logic                                       accept;

    assign accept = sample.valid && sample.ready;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            cavl_pkg::ENG_FETCH:
            begin
                mul_a = {err_reg[DW-1], err_reg};
                mul_b = {1'b0, cfg.angle_kp};
            end
            cavl_pkg::ENG_PD_A:
            begin
                mul_a = derr_reg;
                mul_b = {1'b0, cfg.angle_kd};
            end
            cavl_pkg::ENG_INTEG:
            begin
                mul_a = verr_reg;
                mul_b = {1'b0, cfg.velocity_kp};
            end
            cavl_pkg::ENG_PI_B:
            begin
                mul_a = {integ_reg[DW-1], integ_reg};
                mul_b = {1'b0, cfg.velocity_ki};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Running sum of the two products of a loop stage.
    assign sum     = acc_reg + {prod_reg[cavl_pkg::PROD_W-1], prod_reg};
    assign spd_lim = $signed({{(AW - cavl_pkg::LIMIT_W - GF){1'b0}}, cfg.speed_limit,
                              {GF{1'b0}}});

    // Division by a power of two that rounds toward zero.
    assign t_shift = acc_reg >>> GF;
    assign target  = t_shift[cavl_pkg::DIFF_W-1:0]
                     + $signed({{(cavl_pkg::DIFF_W-1){1'b0}},
                                (acc_reg[AW-1] && (acc_reg[GF-1:0] != '0))});

    assign isum = {{2{iold_reg[DW-1]}}, iold_reg} + {verr_reg[cavl_pkg::DIFF_W-1], verr_reg};
    assign ilim = $signed({{(cavl_pkg::ISUM_W - cavl_pkg::LIMIT_W){1'b0}},
                           cfg.integral_limit});
    assign ilim_neg = -ilim;

    assign d_shift = acc_reg >>> TS;
    assign d_trunc = d_shift[cavl_pkg::DSHIFT_W-1:0]
                     + $signed({{(cavl_pkg::DSHIFT_W-1){1'b0}},
                                (acc_reg[AW-1] && (acc_reg[TS-1:0] != '0))});
    assign vlim    = $signed({{(cavl_pkg::DSHIFT_W - cavl_pkg::VLIM_W){1'b0}},
                              cfg.voltage_limit});
    assign vlim_neg = -vlim;

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        derr_next    = derr_reg;
        verr_next    = verr_reg;
        integ_next   = integ_reg;
        sample.ready = 1'b0;
        res_valid    = 1'b0;
        res_drive    = '0;
        mem_req      = '0;
        case (state_reg)
            cavl_pkg::ENG_IDLE:
            begin
                sample.ready    = 1'b1;
                mem_req.rd_en   = sample.valid;
                mem_req.rd_addr = sample.channel;
                if (sample.valid)
                begin
                    state_next = cavl_pkg::ENG_FETCH;
                end
            end
            cavl_pkg::ENG_FETCH:
            begin
                derr_next  = {err_reg[DW-1], err_reg}
                             - $signed({mem_rd.error[DW-1], mem_rd.error});
                state_next = cavl_pkg::ENG_PD_A;
            end
            cavl_pkg::ENG_PD_A:
            begin
                acc_next   = {prod_reg[cavl_pkg::PROD_W-1], prod_reg};
                state_next = cavl_pkg::ENG_PD_SUM;
            end
            cavl_pkg::ENG_PD_SUM:
            begin
                if (sum > spd_lim)
                begin
                    acc_next = spd_lim;
                end
                else if (sum < -spd_lim)
                begin
                    acc_next = -spd_lim;
                end
                else
                begin
                    acc_next = sum;
                end
                state_next = cavl_pkg::ENG_VERR;
            end
            cavl_pkg::ENG_VERR:
            begin
                verr_next  = target - {vel_reg[DW-1], vel_reg};
                state_next = cavl_pkg::ENG_INTEG;
            end
            cavl_pkg::ENG_INTEG:
            begin
                if (isum > ilim)
                begin
                    integ_next = ilim[DW-1:0];
                end
                else if (isum < ilim_neg)
                begin
                    integ_next = ilim_neg[DW-1:0];
                end
                else
                begin
                    integ_next = isum[DW-1:0];
                end
                mem_req.wr_en       = 1'b1;
                mem_req.wr_addr     = ch_reg;
                mem_req.wr_error    = err_reg;
                mem_req.wr_integral = integ_next;
                state_next          = cavl_pkg::ENG_PI_B;
            end
            cavl_pkg::ENG_PI_B:
            begin
                acc_next   = {prod_reg[cavl_pkg::PROD_W-1], prod_reg};
                state_next = cavl_pkg::ENG_PI_SUM;
            end
            cavl_pkg::ENG_PI_SUM:
            begin
                acc_next   = sum;
                state_next = cavl_pkg::ENG_DRIVE;
            end
            cavl_pkg::ENG_DRIVE:
            begin
                res_valid = 1'b1;
                if (d_trunc > vlim)
                begin
                    res_drive = vlim[cavl_pkg::DRIVE_W-1:0];
                end
                else if (d_trunc < vlim_neg)
                begin
                    res_drive = vlim_neg[cavl_pkg::DRIVE_W-1:0];
                end
                else
                begin
                    res_drive = d_trunc[cavl_pkg::DRIVE_W-1:0];
                end
                if (res_ready)
                begin
                    state_next = cavl_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = cavl_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cavl_pkg::ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= sample.channel;
            err_reg <= sample.angle_error;
            vel_reg <= sample.measured_velocity;
        end
        if (state_reg == cavl_pkg::ENG_FETCH)
        begin
            iold_reg <= mem_rd.integral;
        end
        prod_reg  <= mul_p;
        acc_reg   <= acc_next;
        derr_reg  <= derr_next;
        verr_reg  <= verr_next;
        integ_reg <= integ_next;
    end

endmodule

// ===== rtl/cavl_out_stage.sv =====
// ----------------------------------------------------------------------------
// cavl_out_stage
// Output register that holds a finished drive word until the sink takes it.
// ----------------------------------------------------------------------------
module cavl_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  logic signed [cavl_pkg::DRIVE_W-1:0] res_drive,
    output logic                                res_ready,
    cavl_out_if.source                          drive
);

    logic                                valid_reg;
    logic signed [cavl_pkg::DRIVE_W-1:0] drive_reg;

    assign res_ready = !valid_reg || drive.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            drive_reg <= res_drive;
        end
    end

    assign drive.valid         = valid_reg;
    assign drive.drive_voltage = drive_reg;

endmodule

// ===== rtl/cascaded_angle_velocity_loop_core.sv =====
// ----------------------------------------------------------------------------
// cascaded_angle_velocity_loop_core
// Four-channel cascaded PD position and PI velocity controller with
// per-channel state in a small synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Role    Words
// sample    sink    channel, angle_error, measured_velocity
// drive     source  drive_voltage
// cfg_*     write   cfg_we, cfg_index, cfg_data
//
// A sample word steps through FETCH, PD_A, PD_SUM, VERR, INTEG, PI_B, PI_SUM
// and DRIVE before its drive word enters the output register, and the engine
// then takes the next sample in IDLE; the shared multiplier and the
// accumulator are stepped through the four gain products one after another.
// Reset clears the registers to their defaults and the channel state to zero.
// A stalled drive word holds the engine in its last step; the next sample is
// taken as soon as the finished word sits in the output register.
// ----------------------------------------------------------------------------
module cascaded_angle_velocity_loop_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cavl_in_if.sink                              sample,
    cavl_out_if.source                           drive,
    input  logic                                 cfg_we,
    input  logic [cavl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cavl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    cavl_pkg::cfg_t                       cfg_reg;
    cavl_pkg::mem_req_t                   mem_req;
    cavl_pkg::mem_rd_t                    mem_rd;
    logic                                 res_valid;
    logic                                 res_ready;
    logic signed [cavl_pkg::DRIVE_W-1:0]  res_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_kp       <= cavl_pkg::ANGLE_KP_RESET;
            cfg_reg.angle_kd       <= cavl_pkg::ANGLE_KD_RESET;
            cfg_reg.velocity_kp    <= cavl_pkg::VELOCITY_KP_RESET;
            cfg_reg.velocity_ki    <= cavl_pkg::VELOCITY_KI_RESET;
            cfg_reg.speed_limit    <= cavl_pkg::SPEED_LIMIT_RESET;
            cfg_reg.integral_limit <= cavl_pkg::INTEGRAL_LIMIT_RESET;
            cfg_reg.voltage_limit  <= cavl_pkg::VOLTAGE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cavl_pkg::CFG_ANGLE_KP:
                    cfg_reg.angle_kp <= cfg_data[cavl_pkg::GAIN_W-1:0];
                cavl_pkg::CFG_ANGLE_KD:
                    cfg_reg.angle_kd <= cfg_data[cavl_pkg::GAIN_W-1:0];
                cavl_pkg::CFG_VELOCITY_KP:
                    cfg_reg.velocity_kp <= cfg_data[cavl_pkg::GAIN_W-1:0];
                cavl_pkg::CFG_VELOCITY_KI:
                    cfg_reg.velocity_ki <= cfg_data[cavl_pkg::GAIN_W-1:0];
                cavl_pkg::CFG_SPEED_LIMIT:
                    cfg_reg.speed_limit <= cfg_data[cavl_pkg::LIMIT_W-1:0];
                cavl_pkg::CFG_INTEGRAL_LIMIT:
                    cfg_reg.integral_limit <= cfg_data[cavl_pkg::LIMIT_W-1:0];
                cavl_pkg::CFG_VOLTAGE_LIMIT:
                    cfg_reg.voltage_limit <= cfg_data[cavl_pkg::VLIM_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    cavl_state_mem u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rd    (mem_rd)
    );

    cavl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg       (cfg_reg),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd),
        .res_valid (res_valid),
        .res_drive (res_drive),
        .res_ready (res_ready)
    );

    cavl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_drive (res_drive),
        .res_ready (res_ready),
        .drive     (drive)
    );

endmodule

// ===== rtl/cavl_checker.sv =====
// ----------------------------------------------------------------------------
// cavl_checker
// Port-level checks of the cascaded loop core, bound to the top level.
// ----------------------------------------------------------------------------
module cavl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [cavl_pkg::DRIVE_W-1:0] out_drive
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_drive))
        else $error("drive word changed or dropped while stalled");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_drive != $signed({1'b1, {(cavl_pkg::DRIVE_W-1){1'b0}}}))
        else $error("drive word outside the symmetric range");

    a_accept_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_acc ##1 !in_acc)
        else $error("sample word accepted while a previous one is in work");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (out_valid !== 1'b1))
        else $error("drive word valid during reset");

endmodule

bind cascaded_angle_velocity_loop_core cavl_checker u_cavl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .out_drive (drive.drive_voltage)
);

// ===== tb/cascaded_angle_velocity_loop_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_angle_velocity_loop_core_tb
// Self-checking bench for the four-channel cascaded angle and velocity loop.
// Sample words go in over the valid/ready sink while the drive words are
// collected at the source side. Each accepted sample is run through a
// fixed-point copy of the PD and PI loops to predict its drive word, and
// the drive words are compared in order. The run steps through several
// register settings, including zero and full-scale limits and gains. Sender
// gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module cascaded_angle_velocity_loop_core_tb;

    localparam logic [cavl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PHASES = 9;
    localparam int RANDOM_PER_PHASE = 105;

    class drive_board;
        cavl_pkg::cfg_t                      settings;
        longint                              last_error [cavl_pkg::CHANNELS];
        longint                              error_integral [cavl_pkg::CHANNELS];
        logic signed [cavl_pkg::DRIVE_W-1:0] pending_drive [$];
        int                                  samples_taken;
        int                                  drives_matched;
        int                                  failures;

        function new();
            settings = reset_settings();
            foreach (last_error[i])
            begin
                last_error[i]     = 0;
                error_integral[i] = 0;
            end
        endfunction

        static function cavl_pkg::cfg_t reset_settings();
            cavl_pkg::cfg_t s;
            s.angle_kp       = cavl_pkg::ANGLE_KP_RESET;
            s.angle_kd       = cavl_pkg::ANGLE_KD_RESET;
            s.velocity_kp    = cavl_pkg::VELOCITY_KP_RESET;
            s.velocity_ki    = cavl_pkg::VELOCITY_KI_RESET;
            s.speed_limit    = cavl_pkg::SPEED_LIMIT_RESET;
            s.integral_limit = cavl_pkg::INTEGRAL_LIMIT_RESET;
            s.voltage_limit  = cavl_pkg::VOLTAGE_LIMIT_RESET;
            return s;
        endfunction

        static function longint clamp_mag(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        static function longint toward_zero(longint v, int s);
            if (v < 0)
                return -((-v) >> s);
            return v >> s;
        endfunction

        // Runs one sample through the outer PD and inner PI loops and queues
        // the drive word that it must produce.
        function void queue_predicted_drive(logic [cavl_pkg::CH_W-1:0] ch,
                                            logic signed [cavl_pkg::DATA_W-1:0] err_in,
                                            logic signed [cavl_pkg::DATA_W-1:0] vel_in);
            longint err, vel, derr, pd, speed_cap, target, verr, isum, pi, drv;
            longint akp, akd, vkp, vki, icap, vcap;
            akp       = settings.angle_kp;
            akd       = settings.angle_kd;
            vkp       = settings.velocity_kp;
            vki       = settings.velocity_ki;
            speed_cap = settings.speed_limit;
            icap      = settings.integral_limit;
            vcap      = settings.voltage_limit;
            err       = err_in;
            vel       = vel_in;
            derr      = err - last_error[ch];
            last_error[ch] = err;
            pd        = clamp_mag(err * akp + derr * akd, speed_cap * 256);
            target    = toward_zero(pd, cavl_pkg::GAIN_FRAC);
            verr      = target - vel;
            isum      = clamp_mag(error_integral[ch] + verr, icap);
            error_integral[ch] = isum;
            pi        = verr * vkp + isum * vki;
            drv       = clamp_mag(toward_zero(pi, cavl_pkg::FRAC_BITS + cavl_pkg::GAIN_FRAC),
                                  vcap);
            pending_drive.push_back(drv[cavl_pkg::DRIVE_W-1:0]);
            samples_taken++;
        endfunction

        function void match_drive(logic signed [cavl_pkg::DRIVE_W-1:0] got);
            logic signed [cavl_pkg::DRIVE_W-1:0] want;
            if (pending_drive.size() == 0)
            begin
                $error("drive word %0d arrived with nothing expected", got);
                failures++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (got !== want)
                begin
                    $error("drive_voltage mismatch: expected %0d, actual %0d", want, got);
                    failures++;
                end
                else
                    drives_matched++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                            cfg_we;
    logic [cavl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cavl_pkg::CFG_DATA_W-1:0] cfg_data;

    cavl_in_if  sample_bus ();
    cavl_out_if drive_bus ();

    drive_board board = new();
    int         send_idle_pct;
    int         recv_stall_pct;
    int         settings_applied;
    int         err_drift [cavl_pkg::CHANNELS];
    int         vel_drift [cavl_pkg::CHANNELS];

    cascaded_angle_velocity_loop_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_bus),
        .drive     (drive_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_bus.valid && drive_bus.ready)
            board.match_drive(drive_bus.drive_voltage);
        drive_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while ($urandom_range(99) < pct && g < 40)
            g++;
        return g;
    endfunction

    function automatic logic [cavl_pkg::GAIN_W-1:0] pick_gain();
        if ($urandom_range(1) == 0)
            return cavl_pkg::GAIN_W'($urandom);
        return cavl_pkg::GAIN_W'($urandom_range(0, 40000));
    endfunction

    function automatic logic [cavl_pkg::LIMIT_W-1:0] pick_limit();
        if ($urandom_range(2) == 0)
            return cavl_pkg::LIMIT_W'($urandom);
        return cavl_pkg::LIMIT_W'($urandom_range(0, 8000000));
    endfunction

    function automatic cavl_pkg::cfg_t settings_for(int phase);
        cavl_pkg::cfg_t s;
        s.angle_kp       = pick_gain();
        s.angle_kd       = pick_gain();
        s.velocity_kp    = pick_gain();
        s.velocity_ki    = pick_gain();
        s.speed_limit    = pick_limit();
        s.integral_limit = pick_limit();
        s.voltage_limit  = cavl_pkg::VLIM_W'($urandom);
        case (phase)
            1: s = '1;
            2:
            begin
                s.speed_limit    = '0;
                s.integral_limit = '1;
                s.voltage_limit  = '1;
            end
            3: s.integral_limit = '0;
            4: s.voltage_limit = '0;
            5: s = '0;
            8: s = drive_board::reset_settings();
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [cavl_pkg::CFG_DATA_W-1:0] register_value(
        cavl_pkg::cfg_t s, cavl_pkg::cfg_index_t idx);
        case (idx)
            cavl_pkg::CFG_ANGLE_KP:       return cavl_pkg::CFG_DATA_W'(s.angle_kp);
            cavl_pkg::CFG_ANGLE_KD:       return cavl_pkg::CFG_DATA_W'(s.angle_kd);
            cavl_pkg::CFG_VELOCITY_KP:    return cavl_pkg::CFG_DATA_W'(s.velocity_kp);
            cavl_pkg::CFG_VELOCITY_KI:    return cavl_pkg::CFG_DATA_W'(s.velocity_ki);
            cavl_pkg::CFG_SPEED_LIMIT:    return cavl_pkg::CFG_DATA_W'(s.speed_limit);
            cavl_pkg::CFG_INTEGRAL_LIMIT: return cavl_pkg::CFG_DATA_W'(s.integral_limit);
            cavl_pkg::CFG_VOLTAGE_LIMIT:  return cavl_pkg::CFG_DATA_W'(s.voltage_limit);
            default:                      return '0;
        endcase
    endfunction

    function automatic logic signed [cavl_pkg::DATA_W-1:0] make_value(int center, int span);
        case ($urandom_range(9))
            0: return cavl_pkg::DATA_W'($urandom);
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return 32'shffff_ffff;
                endcase
            end
            default: return center + int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic apply_settings(input cavl_pkg::cfg_t s, input bit junk);
        cavl_pkg::cfg_index_t idx;
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= register_value(s, idx);
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        // A write to the spare index must leave every register alone.
        if (junk)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= cavl_pkg::CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        board.settings = s;
        settings_applied++;
    endtask

    task automatic send_sample(input logic [cavl_pkg::CH_W-1:0] ch,
                               input logic signed [cavl_pkg::DATA_W-1:0] err,
                               input logic signed [cavl_pkg::DATA_W-1:0] vel);
        int gap;
        gap = idle_gap(send_idle_pct);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid             <= 1'b1;
        sample_bus.channel           <= ch;
        sample_bus.angle_error       <= err;
        sample_bus.measured_velocity <= vel;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        board.queue_predicted_drive(ch, err, vel);
    endtask

    task automatic send_random();
        logic [cavl_pkg::CH_W-1:0] ch;
        ch = cavl_pkg::CH_W'($urandom);
        // Slowly drifting errors let the integrals wind up to their limits.
        if ($urandom_range(15) == 0)
        begin
            err_drift[ch] = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            vel_drift[ch] = int'($urandom_range(0, 32'h0050_0000)) - 32'h0028_0000;
        end
        send_sample(ch, make_value(err_drift[ch], 32'h0001_0000),
                    make_value(vel_drift[ch], 32'h0004_0000));
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (board.pending_drive.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk                          = 1'b0;
        rst_n                        = 1'b0;
        cfg_we                       = 1'b0;
        cfg_index                    = '0;
        cfg_data                     = '0;
        sample_bus.valid             = 1'b0;
        sample_bus.channel           = '0;
        sample_bus.angle_error       = '0;
        sample_bus.measured_velocity = '0;
        drive_bus.ready              = 1'b0;
        send_idle_pct                = 0;
        recv_stall_pct               = 0;
        settings_applied             = 0;
        foreach (err_drift[i])
        begin
            err_drift[i] = 0;
            vel_drift[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct  = (phase % 4 == 1) ? 46 : (phase % 4 == 3) ? 26 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 46 : (phase % 4 == 3) ? 26 : 0;
            if (phase != 0)
                apply_settings(settings_for(phase), phase >= 5);
            if (phase == 0)
            begin
                send_sample(2'd0, 32'sh0000_0000, 32'sh0000_0000);
                send_sample(2'd0, 32'sh7fff_ffff, 32'sh0000_0000);
                send_sample(2'd0, 32'sh8000_0000, 32'sh0000_0000);
                send_sample(2'd0, 32'sh8000_0000, 32'sh7fff_ffff);
                send_sample(2'd1, 32'sh0000_0001, 32'sh8000_0000);
                send_sample(2'd1, 32'shffff_ffff, 32'sh7fff_ffff);
                send_sample(2'd1, 32'sh0000_0000, 32'sh0000_0000);
                for (int k = 0; k < 6; k++)
                    send_sample(2'd2, 32'sh0001_0000, 32'sh0000_0000);
                send_sample(2'd2, 32'sh0000_0000, 32'sh0000_0000);
                for (int k = 0; k < 3; k++)
                    send_sample(2'd3, 32'shfff0_0000, 32'sh0014_0000);
                send_sample(2'd3, 32'sh7fff_ffff, 32'sh8000_0000);
                send_sample(2'd3, 32'sh0000_0000, 32'sh0000_0000);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 3 && n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                send_random();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Checked %0d drive words from %0d samples over %0d register settings.",
                 board.drives_matched, board.samples_taken, settings_applied + 1);
        $display("Covered zero and full-scale limits and gains, sender gaps and receiver stalls.");
        if (board.failures == 0 && board.pending_drive.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
